### hdl/slid_pkg.sv
// Shared types and codes for the sorted list insert/delete unit.
// Holds action, status and cell operation codes and the cell control struct.
// No dependencies.
`default_nettype none

package slid_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned CountOutW   = 5;

  // Requested action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_DUMP   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // Operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROT
  } slid_op_t;

  typedef struct packed {
    slid_op_t            code;
    logic [ValueW-1:0]   key;
  } slid_ctrl_t;

endpackage

`default_nettype wire

### hdl/sorted_list_insert_delete_unit.sv
// Sorted list insert/delete unit: top level, chain of slid_cell instances
// plus the action sequencer and output register. Depends on slid_pkg, slid_cell.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item: action and item_value.
//   Output channel (out_valid/out_ready) carries results: status, entry_value,
//   entry_count and last. Every item yields one or more results, the final
//   one marked by last.
//   Insert and delete take effect in the accept cycle: every cell compares
//   against the key in parallel and the cells from the key's place on shift;
//   the unused code changes nothing. The result is visible the next cycle.
//   Dump starts the cycle after its accept, then rotates the valid run of
//   cells one place per result and leaves it in its original order; the first
//   entry is loaded into the output register from the dump state. An empty
//   table gives one result flagged empty, visible the next cycle.
//   Throughput: one insert/delete per cycle while results are taken each
//   cycle; a dump holds off new items until its last entry is emitted, and
//   an empty dump never leaves idle. The single output register sets the rate.
//   A stalled receiver holds the output register; the next item is taken in
//   the same cycle the pending result leaves. During a dump the rotation
//   advances only as results are taken.
//   Reset (rst, synchronous) empties the table and drops any pending result.
`default_nettype none

module sorted_list_insert_delete_unit
  import slid_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
)
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 action,
  input  wire logic signed [ValueW-1:0]   item_value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      status,
  output logic signed [ValueW-1:0]        entry_value,
  output logic [CountOutW-1:0]            entry_count,
  output logic                            last
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t      state;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] idx;
  slid_ctrl_t  ctrl;

  logic [ValueW-1:0] cell_value [CAPACITY];
  logic              cell_valid [CAPACITY];
  logic              cell_lt    [CAPACITY];
  logic              cell_found [CAPACITY];

  logic in_fire;
  logic out_free;
  logic full;
  logic found_any;
  logic dump_step;
  logic dump_last;
  logic [31:0] count_ext;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign full      = (count == CW'(CAPACITY));
  assign found_any = cell_found[CAPACITY-1];
  assign dump_step = (state == S_DUMP) && out_free;
  assign dump_last = (idx == (count - CW'(1)));

  // Broadcast operation to the whole chain
  always_comb begin
    ctrl.key  = item_value;
    ctrl.code = OP_HOLD;
    if (in_fire) begin
      case (action)
        ACT_INSERT: ctrl.code = full ? OP_HOLD : OP_INS;
        // only cells from the first match on shift; a miss moves nothing
        ACT_DELETE: ctrl.code = OP_DEL;
        default:    ctrl.code = OP_HOLD;
      endcase
    end else if (dump_step) begin
      ctrl.code = OP_ROT;
    end
  end

  // Cell chain: each cell sees its left and right neighbors and the head value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ValueW-1:0] lv;
    logic              lvld;
    logic              llt;
    logic              fin;
    logic [ValueW-1:0] rv;
    logic              rvld;

    if (i == 0) begin : g_head
      assign lv   = '0;
      assign lvld = 1'b1;
      assign llt  = 1'b1;
      assign fin  = 1'b0;
    end else begin : g_body
      assign lv   = cell_value[i-1];
      assign lvld = cell_valid[i-1];
      assign llt  = cell_lt[i-1];
      assign fin  = cell_found[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rv   = '0;
      assign rvld = 1'b0;
    end else begin : g_mid
      assign rv   = cell_value[i+1];
      assign rvld = cell_valid[i+1];
    end

    slid_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .head_value  (cell_value[0]),
      .left_value  (lv),
      .left_valid  (lvld),
      .left_lt     (llt),
      .right_value (rv),
      .right_valid (rvld),
      .found_in    (fin),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .lt          (cell_lt[i]),
      .found_out   (cell_found[i])
    );
  end

  // Fill count after the accepted action
  always_comb begin
    count_next = count;
    if (in_fire) begin
      case (action)
        ACT_INSERT: if (!full) count_next = count + CW'(1);
        ACT_DELETE: if (found_any) count_next = count - CW'(1);
        default:    count_next = count;
      endcase
    end
  end

  assign count_ext = 32'(count_next);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            out_valid   <= 1'b1;
            entry_value <= '0;
            entry_count <= count_ext[CountOutW-1:0];
            last        <= 1'b1;
            case (action)
              ACT_INSERT: status <= full ? ST_FULL : ST_OK;
              ACT_DELETE: status <= found_any ? ST_OK : ST_NOT_FOUND;
              ACT_DUMP: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                end else begin
                  // hold off the result; the dump loop emits the entries
                  out_valid <= 1'b0;
                  idx       <= '0;
                  state     <= S_DUMP;
                end
              end
              default: status <= ST_OK;
            endcase
          end
        end
        S_DUMP: begin
          if (dump_step) begin
            out_valid   <= 1'b1;
            status      <= ST_OK;
            entry_value <= cell_value[0];
            entry_count <= count_ext[CountOutW-1:0];
            last        <= dump_last;
            idx         <= idx + CW'(1);
            if (dump_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  logic [CAPACITY-1:0] valid_vec;
  for (genvar j = 0; j < CAPACITY; j++) begin : g_vv
    assign valid_vec[j] = cell_valid[j];
  end

  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(count))
    else $error("fill count disagrees with valid cells");

  a_dump_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |-> (count != '0) && (idx < count))
    else $error("dump running past the table");

  a_full_insert_keeps: assert property (@(posedge clk) disable iff (rst)
    (in_fire && action == ACT_INSERT && full) |=> $stable(count))
    else $error("insert into full table changed the count");

endmodule

`default_nettype wire

### hdl/slid_cell.sv
// One storage cell of the sorted chain: a value, its valid bit and the
// local compare logic. Depends on slid_pkg.
`default_nettype none

module slid_cell
  import slid_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire slid_ctrl_t        ctrl,
  input  wire logic [ValueW-1:0] head_value,
  input  wire logic [ValueW-1:0] left_value,
  input  wire logic              left_valid,
  input  wire logic              left_lt,
  input  wire logic [ValueW-1:0] right_value,
  input  wire logic              right_valid,
  input  wire logic              found_in,
  output logic [ValueW-1:0]      value,
  output logic                   valid,
  output logic                   lt,
  output logic                   found_out
);

  logic [ValueW-1:0] value_next;
  logic              valid_next;
  logic              match;

  assign lt        = valid && ($signed(value) < $signed(ctrl.key));
  assign match     = valid && (value == ctrl.key);
  assign found_out = found_in | match;

  always_comb begin
    value_next = value;
    valid_next = valid;
    case (ctrl.code)
      OP_INS: begin
        // keep smaller entries, drop the key at the boundary, shift the rest
        if (!lt) begin
          value_next = left_lt ? ctrl.key : left_value;
        end
        valid_next = left_valid;
      end
      OP_DEL: begin
        if (found_out) begin
          value_next = right_value;
          valid_next = right_valid;
        end
      end
      OP_ROT: begin
        // rotate within the valid run; the last valid cell takes the head
        if (right_valid) begin
          value_next = right_value;
        end else if (valid) begin
          value_next = head_value;
        end
      end
      default: begin
        value_next = value;
        valid_next = valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      value <= '0;
    end else begin
      valid <= valid_next;
      value <= value_next;
    end
  end

endmodule

`default_nettype wire
